FILE: hdl/aes_pkg.sv
package aes_pkg;

	localparam int unsigned KeyWidth   = 64;
	localparam int unsigned BlockWidth = 128;
	localparam int unsigned NumRounds  = 10;
	localparam int unsigned NumRk      = NumRounds + 1;
	localparam int unsigned RoundW     = $clog2(NumRk + 1);

	localparam logic [0:0] ACT_ENC = 1'b0;
	localparam logic [0:0] ACT_DEC = 1'b1;

	localparam logic [0:0] REG_KEY_HIGH = 1'b0;
	localparam logic [0:0] REG_KEY_LOW  = 1'b1;

	localparam logic [7:0] GfPoly = 8'h1B;

	localparam logic [7:0] FwdSub [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] InvSub [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xt(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? GfPoly : 8'h00);
	endfunction

	function automatic logic [31:0] mix_col(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3;
		a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
		return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
			a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
			a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
			xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
	endfunction

	function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3, u, v;
		a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
		u = xt(xt(a0 ^ a2));
		v = xt(xt(a1 ^ a3));
		return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {FwdSub[w[31:24]], FwdSub[w[23:16]], FwdSub[w[15:8]], FwdSub[w[7:0]]};
	endfunction

	typedef struct packed {
		logic       start;
		logic [127:0] key;
	} ks_ctl_t;

	typedef struct packed {
		logic busy;
	} ks_sts_t;

endpackage

FILE: hdl/aes_stream_if.sv
interface aes_stream_if #(parameter int unsigned W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/aes_ram.sv
module aes_ram #(
	parameter int unsigned Width = 64,
	parameter int unsigned Depth = 22
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr_a,
	output logic [Width-1:0]         rdata_a,
	input  logic [$clog2(Depth)-1:0] raddr_b,
	output logic [Width-1:0]         rdata_b
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end
endmodule

FILE: hdl/aes_key_sched.sv
module aes_key_sched (
	input  logic              clk,
	input  logic              arst_n,
	input  aes_pkg::ks_ctl_t  ctl,
	output aes_pkg::ks_sts_t  sts,
	output logic              we,
	output logic [4:0]        waddr,
	output logic [63:0]       wdata
);
	logic [127:0] rk_q;
	logic [7:0]   rcon_q;
	logic [4:0]   idx_q;
	logic         busy_q;
	logic [31:0]  t;
	logic [31:0]  w0, w1, w2, w3;
	logic [127:0] nxt;

	always_comb begin
		t  = aes_pkg::sub_word({rk_q[23:0], rk_q[31:24]}) ^ {rcon_q, 24'h0};
		w0 = rk_q[127:96] ^ t;
		w1 = rk_q[95:64] ^ w0;
		w2 = rk_q[63:32] ^ w1;
		w3 = rk_q[31:0] ^ w2;
		nxt = {w0, w1, w2, w3};
	end

	// write high half on even index, low half on odd, advance key after low
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			rcon_q <= 8'h01;
			rk_q   <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			rcon_q <= 8'h01;
			rk_q   <= ctl.key;
		end else if (busy_q) begin
			idx_q <= idx_q + 5'd1;
			if (idx_q[0]) begin
				rk_q   <= nxt;
				rcon_q <= aes_pkg::xt(rcon_q);
			end
			if (idx_q == 5'(2 * aes_pkg::NumRk - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign we       = busy_q && !ctl.start;
	assign waddr    = idx_q;
	assign wdata    = idx_q[0] ? rk_q[63:0] : rk_q[127:64];
	assign sts.busy = busy_q;
endmodule

FILE: hdl/aes128_block_cipher.sv
// AES-128 encrypt/decrypt, one 128-bit word at a time. A key write re-expands the
// eleven round keys into a 22-entry store at one half per cycle (also after reset);
// no word is accepted until that finishes. On its way from acceptance to the earliest
// result handshake a word passes the round-key read in the accepting cycle, the
// initial key addition, ten rounds through a single shared round unit, and an output
// register. The input is free again once the last round ends, while the result waits
// in the output register; if that register is still full when the last round ends,
// the finished word is held and the input stays blocked.
module aes128_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	aes_stream_if.sink   in_ch,
	aes_stream_if.source out_ch,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t       state_q;
	logic [63:0]  key_high_q, key_low_q;
	logic [127:0] s_q;
	logic         dec_q;
	logic [3:0]   rnd_q;
	logic         first_q;
	aes_pkg::ks_ctl_t ks_ctl;
	aes_pkg::ks_sts_t ks_sts;
	logic         ks_we;
	logic [4:0]   ks_waddr;
	logic [63:0]  ks_wdata;
	logic [4:0]   ra, rb;
	logic [63:0]  rd_a, rd_b;
	logic [127:0] rk;
	logic [127:0] sb, sr, mc, rnd_out;
	logic [3:0]   rnd_use;
	logic         in_fire;
	logic         last_rnd;
	logic         out_free;
	logic         out_load;
	logic [127:0] out_q;
	logic         out_valid_q;

	assign in_fire = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && !ks_sts.busy && !cfg_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_index == aes_pkg::REG_KEY_HIGH) key_high_q <= cfg_data;
			else key_low_q <= cfg_data;
		end
	end

	assign ks_ctl.start = cfg_we;
	assign ks_ctl.key = (cfg_index == aes_pkg::REG_KEY_HIGH) ? {cfg_data, key_low_q}
		: {key_high_q, cfg_data};

	aes_key_sched u_ks (
		.clk(clk), .arst_n(arst_n), .ctl(ks_ctl), .sts(ks_sts),
		.we(ks_we), .waddr(ks_waddr), .wdata(ks_wdata)
	);

	// round number the next cycle will use
	always_comb begin
		if (in_fire) rnd_use = in_ch.data[128] ? 4'(aes_pkg::NumRounds) : 4'd0;
		else if (dec_q) rnd_use = rnd_q - 4'd1;
		else rnd_use = rnd_q + 4'd1;
	end
	assign ra = {rnd_use, 1'b0};
	assign rb = {rnd_use, 1'b1};

	aes_ram #(.Width(64), .Depth(2 * aes_pkg::NumRk)) u_rk (
		.clk(clk), .we(ks_we), .waddr(ks_waddr), .wdata(ks_wdata),
		.raddr_a(ra), .rdata_a(rd_a), .raddr_b(rb), .rdata_b(rd_b)
	);
	assign rk = {rd_a, rd_b};

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (!dec_q) begin
					sb[127 - 8*(4*c+r) -: 8] = aes_pkg::FwdSub[s_q[127 - 8*(4*c+r) -: 8]];
				end else begin
					sb[127 - 8*(4*c+r) -: 8] = aes_pkg::InvSub[s_q[127 - 8*(4*c+r) -: 8]];
				end
			end
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sr[127 - 8*(4*c+r) -: 8] = dec_q
					? sb[127 - 8*(4*((c + 3*r) & 3) + r) -: 8]
					: sb[127 - 8*(4*((c + r) & 3) + r) -: 8];
			end
		end
		for (int c = 0; c < 4; c++) begin
			mc[127 - 32*c -: 32] = dec_q
				? aes_pkg::inv_mix_col(sr[127 - 32*c -: 32] ^ rk[127 - 32*c -: 32])
				: aes_pkg::mix_col(sr[127 - 32*c -: 32]) ^ rk[127 - 32*c -: 32];
		end
		if (first_q) rnd_out = s_q ^ rk;
		else if (dec_q ? (rnd_q == 4'd0) : (rnd_q == 4'(aes_pkg::NumRounds))) rnd_out = sr ^ rk;
		else rnd_out = mc;
	end

	assign last_rnd = !first_q
		&& (dec_q ? (rnd_q == 4'd0) : (rnd_q == 4'(aes_pkg::NumRounds)));
	assign out_free = !out_valid_q || out_ch.ready;
	assign out_load = out_free
		&& (((state_q == ST_RUN) && last_rnd) || (state_q == ST_OUT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dec_q   <= 1'b0;
			rnd_q   <= '0;
			first_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						dec_q   <= in_ch.data[128];
						rnd_q   <= in_ch.data[128] ? 4'(aes_pkg::NumRounds) : 4'd0;
						first_q <= 1'b1;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					first_q <= 1'b0;
					if (last_rnd) begin
						state_q <= out_free ? ST_IDLE : ST_OUT;
					end
					rnd_q <= rnd_use;
				end
				ST_OUT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// first cycle loads the word; rnd_q then tracks the key just read
	always_ff @(posedge clk) begin
		if (in_fire) s_q <= in_ch.data[127:0];
		else if (state_q == ST_RUN) s_q <= rnd_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_q <= (state_q == ST_OUT) ? s_q : rnd_out;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	chk_one_hot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	chk_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ks_sts.busy |-> !in_ch.ready) else $error("accept during key expansion");
	chk_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
		else $error("result dropped");
endmodule

FILE: bench/aes128_block_cipher_tb.sv
`timescale 1ns / 100ps

module aes128_block_cipher_tb;

	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned LongHold   = 400;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [63:0] cfg_data;

	aes_stream_if #(.W(aes_pkg::BlockWidth + 1)) in_if ();
	aes_stream_if #(.W(aes_pkg::BlockWidth))     out_if ();

	aes128_block_cipher uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_if.sink),
		.out_ch(out_if.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [7:0]   sbox_fwd [256];
	logic [7:0]   sbox_inv [256];
	logic [63:0]  cur_key_high;
	logic [63:0]  cur_key_low;
	logic [127:0] sched [11];
	logic [127:0] cipher_q [$];
	int unsigned  errors;
	int unsigned  cycles;
	bit           idle_on;
	bit           hold_req;
	int unsigned  hold_left;
	int unsigned  stall_left;

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				acc ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
		end
		return acc;
	endfunction

	function automatic void build_sbox();
		logic [7:0] x, y;
		for (int i = 0; i < 256; i++) begin
			x = 8'h00;
			for (int j = 1; j < 256; j++)
				if (gf_mul(i[7:0], j[7:0]) == 8'h01)
					x = j[7:0];
			y = x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]}
				^ {x[3:0], x[7:4]} ^ 8'h63;
			sbox_fwd[i] = y;
			sbox_inv[y] = i[7:0];
		end
	endfunction

	function automatic void expand_schedule();
		logic [7:0] w [176];
		logic [7:0] t [4];
		logic [7:0] t0, rc;
		logic [127:0] key;
		key = {cur_key_high, cur_key_low};
		rc = 8'h01;
		for (int i = 0; i < 16; i++)
			w[i] = key[127 - 8 * i -: 8];
		for (int i = 16; i < 176; i += 4) begin
			for (int r = 0; r < 4; r++)
				t[r] = w[i - 4 + r];
			if (i % 16 == 0) begin
				t0 = t[0];
				t[0] = sbox_fwd[t[1]] ^ rc;
				t[1] = sbox_fwd[t[2]];
				t[2] = sbox_fwd[t[3]];
				t[3] = sbox_fwd[t0];
				rc = gf_mul(rc, 8'h02);
			end
			for (int r = 0; r < 4; r++)
				w[i + r] = w[i - 16 + r] ^ t[r];
		end
		for (int k = 0; k < 11; k++)
			for (int i = 0; i < 16; i++)
				sched[k][127 - 8 * i -: 8] = w[16 * k + i];
	endfunction

	function automatic logic [127:0] sub_shift(input logic [127:0] v, input bit inv);
		logic [127:0] o;
		int src;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				src = 4 * ((c + (inv ? 3 : 1) * r) % 4) + r;
				o[127 - 8 * (4 * c + r) -: 8] = inv ? sbox_inv[v[127 - 8 * src -: 8]]
					: sbox_fwd[v[127 - 8 * src -: 8]];
			end
		return o;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] v, input bit inv);
		logic [7:0] coef [4];
		logic [7:0] acc;
		logic [127:0] o;
		if (inv)
			coef = '{8'd14, 8'd11, 8'd13, 8'd9};
		else
			coef = '{8'd2, 8'd3, 8'd1, 8'd1};
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				acc = 8'h00;
				for (int k = 0; k < 4; k++)
					acc ^= gf_mul(v[127 - 8 * (4 * c + k) -: 8], coef[(k - r + 4) % 4]);
				o[127 - 8 * (4 * c + r) -: 8] = acc;
			end
		return o;
	endfunction

	function automatic logic [127:0] aes_block(input logic act, input logic [127:0] blk);
		logic [127:0] s;
		if (act == aes_pkg::ACT_ENC) begin
			s = blk ^ sched[0];
			for (int rnd = 1; rnd <= 10; rnd++) begin
				s = sub_shift(s, 1'b0);
				if (rnd < 10)
					s = mix_columns(s, 1'b0);
				s ^= sched[rnd];
			end
		end else begin
			s = blk ^ sched[10];
			for (int rnd = 9; rnd >= 0; rnd--) begin
				s = sub_shift(s, 1'b1) ^ sched[rnd];
				if (rnd > 0)
					s = mix_columns(s, 1'b1);
			end
		end
		return s;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LongHold;
		end
		if (hold_left > 0) begin
			out_if.ready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			out_if.ready <= 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			out_if.ready <= 1'b0;
			stall_left = $urandom_range(0, 10);
		end else begin
			out_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		logic [127:0] exp_blk;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (cipher_q.size() == 0) begin
				$error("unexpected word %h", out_if.data);
				errors++;
			end else begin
				exp_blk = cipher_q.pop_front();
				if (out_if.data[127:64] !== exp_blk[127:64]) begin
					$error("result_high expected %h actual %h", exp_blk[127:64],
						out_if.data[127:64]);
					errors++;
				end
				if (out_if.data[63:0] !== exp_blk[63:0]) begin
					$error("result_low expected %h actual %h", exp_blk[63:0],
						out_if.data[63:0]);
					errors++;
				end
			end
		end
	end

	task automatic send_word(input logic act, input logic [63:0] bh, input logic [63:0] bl);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.data <= {act, bh, bl};
		do
			@(posedge clk);
		while (!in_if.ready);
		cipher_q.push_back(aes_block(act, {bh, bl}));
	endtask

	task automatic drain_words();
		in_if.valid <= 1'b0;
		wait (cipher_q.size() == 0);
		@(posedge clk);
	endtask

	task automatic write_key(input logic [0:0] idx, input logic [63:0] val);
		drain_words();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == aes_pkg::REG_KEY_HIGH)
			cur_key_high = val;
		else
			cur_key_low = val;
		expand_schedule();
	endtask

	task automatic send_random(input int unsigned n);
		repeat (n)
			send_word(1'($urandom_range(0, 1)), rand64(), rand64());
	endtask

	task automatic test_reset_key();
		send_word(aes_pkg::ACT_ENC, '0, '0);
		send_word(aes_pkg::ACT_DEC, '0, '0);
		send_word(aes_pkg::ACT_ENC, '1, '1);
		send_word(aes_pkg::ACT_DEC, '1, '1);
	endtask

	task automatic test_known_vector();
		write_key(aes_pkg::REG_KEY_HIGH, 64'h0001020304050607);
		write_key(aes_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
		send_word(aes_pkg::ACT_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
		send_word(aes_pkg::ACT_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
		send_word(aes_pkg::ACT_ENC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
		send_word(aes_pkg::ACT_DEC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
		send_word(aes_pkg::ACT_ENC, 64'h8000000000000000, 64'h0000000000000001);
	endtask

	task automatic test_key_extremes();
		write_key(aes_pkg::REG_KEY_HIGH, '1);
		write_key(aes_pkg::REG_KEY_LOW, '1);
		send_word(aes_pkg::ACT_ENC, '0, '1);
		send_word(aes_pkg::ACT_DEC, '1, '0);
		write_key(aes_pkg::REG_KEY_LOW, '0);
		send_word(aes_pkg::ACT_ENC, '1, '0);
		send_word(aes_pkg::ACT_DEC, '0, '1);
		write_key(aes_pkg::REG_KEY_HIGH, '0);
		send_word(aes_pkg::ACT_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210);
		send_word(aes_pkg::ACT_DEC, 64'h0123456789abcdef, 64'hfedcba9876543210);
	endtask

	task automatic test_key_changes();
		for (int p = 0; p < 8; p++) begin
			write_key(aes_pkg::REG_KEY_HIGH, rand64());
			if (p % 2 == 0)
				write_key(aes_pkg::REG_KEY_LOW, rand64());
			send_random(170);
		end
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		send_random(40);
		drain_words();
		send_random(60);
	endtask

	task automatic test_full_rate();
		idle_on = 1'b0;
		write_key(aes_pkg::REG_KEY_LOW, rand64());
		send_random(275);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = aes_pkg::REG_KEY_HIGH;
		cfg_data = '0;
		in_if.valid = 1'b0;
		in_if.data = '0;
		out_if.ready = 1'b0;
		errors = 0;
		cycles = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		hold_left = 0;
		stall_left = 0;
		cur_key_high = '0;
		cur_key_low = '0;
		build_sbox();
		expand_schedule();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_key();
		test_known_vector();
		test_key_extremes();
		test_key_changes();
		test_backpressure();
		test_full_rate();
		drain_words();
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
